/* rtl/bgmap_cell_address_top_assert.svh */
// assertion macros shared by the checker of the cell address generator
`ifndef BGMAP_CELL_ADDRESS_TOP_ASSERT_SVH
`define BGMAP_CELL_ADDRESS_TOP_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define BGM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define BGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bgm_pkg.sv */
// widths, register indexes and constants of the background map cell address generator
`default_nettype none

package bgm_pkg;

    // field widths
    localparam int WIN_W      = 10;
    localparam int BIAS_W     = 13;
    localparam int AFF_W      = 16;
    localparam int CELL_W     = 16;
    localparam int PIX_W      = 3;
    localparam int MODE_W     = 2;
    localparam int ORG_W      = 13;
    localparam int MPAR_W     = 10;
    localparam int SEG_W      = 2;
    localparam int SEG_COUNT  = 1 << SEG_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAP_MODE      = 3'd0,
        CFG_ORIGIN_X      = 3'd1,
        CFG_PARALLAX      = 3'd2,
        CFG_ORIGIN_Y      = 3'd3,
        CFG_WIDTH_SEGS    = 3'd4,
        CFG_HEIGHT_SEGS   = 3'd5,
        CFG_OVERFLOW_EN   = 3'd6,
        CFG_OVERFLOW_CELL = 3'd7
    } t_cfg_idx;

    // map modes, code 3 behaves as normal
    localparam logic [MODE_W-1:0] MODE_HBIAS  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_AFFINE = 2'd2;

    // datapath widths
    localparam int POS_W      = 32;              // source position
    localparam int CX_W       = POS_W - PIX_W;   // cell coordinate
    localparam int NX_W       = 16;              // normal/h-bias position
    localparam int B_W        = AFF_W + 1;       // affine pixel distance
    localparam int PROD_W     = AFF_W + B_W;     // step times distance
    localparam int T_W        = PROD_W + 1;      // position in 1/512 units
    localparam int AFF_UP     = 6;               // 13.3 start to 1/512 units
    localparam int FRAC_SHIFT = 9;
    localparam int RND_HALF   = 1 << (FRAC_SHIFT - 1);
    localparam int RCP_SHIFT  = CX_W;            // reciprocal scale for the modulo

    // register stages from input transfer to output register
    localparam int PIPE_DEPTH = 7;

endpackage

`default_nettype wire

/* rtl/bgm_pix_if.sv */
// pixel request channel: window position, eye and row parameters
`default_nettype none

interface bgm_pix_if import bgm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [WIN_W-1:0]         window_x;
    logic [WIN_W-1:0]         window_y;
    logic                     right_eye;
    logic signed [BIAS_W-1:0] bias_left;
    logic signed [BIAS_W-1:0] bias_right;
    logic signed [AFF_W-1:0]  affine_start_x;
    logic signed [AFF_W-1:0]  affine_start_y;
    logic signed [AFF_W-1:0]  affine_step_x;
    logic signed [AFF_W-1:0]  affine_step_y;
    logic signed [AFF_W-1:0]  affine_parallax;

    modport source (
        output valid, window_x, window_y, right_eye, bias_left, bias_right,
               affine_start_x, affine_start_y, affine_step_x, affine_step_y,
               affine_parallax,
        input  ready
    );

    modport sink (
        input  valid, window_x, window_y, right_eye, bias_left, bias_right,
               affine_start_x, affine_start_y, affine_step_x, affine_step_y,
               affine_parallax,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/bgm_cell_if.sv */
// cell address channel: map cell index and pixel offsets within the character
`default_nettype none

interface bgm_cell_if import bgm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cell_index;
    logic [PIX_W-1:0]  pixel_col;
    logic [PIX_W-1:0]  pixel_row;

    modport source (
        output valid, cell_index, pixel_col, pixel_row,
        input  ready
    );

    modport sink (
        input  valid, cell_index, pixel_col, pixel_row,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/bgmap_cell_address_top.sv */
// background map cell address generator, seven-stage pipeline
// throughput: one pixel per cycle while the output is not stalled, set by the single shared stage enable
// all stages stall together while a result waits on o_cell, nothing is dropped
// reset clears the stage valid bits and all configuration registers to 0
`default_nettype none

module bgmap_cell_address_top import bgm_pkg::*; #(
    parameter int SEGMENT_CELLS_WIDE = 64,
    parameter int SEGMENT_CELLS_HIGH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    bgm_pix_if.sink                    i_pix,
    bgm_cell_if.source                 o_cell
);

    // map geometry
    localparam int W_MAX  = SEG_COUNT * SEGMENT_CELLS_WIDE;
    localparam int H_MAX  = SEG_COUNT * SEGMENT_CELLS_HIGH;
    localparam int WS_W   = $clog2(W_MAX + 1);     // map width in cells
    localparam int HS_W   = $clog2(H_MAX + 1);
    localparam int REMX_W = $clog2(W_MAX);         // wrapped cell column
    localparam int REMY_W = $clog2(H_MAX);
    localparam int ESTX_W = $clog2(2 * W_MAX);     // remainder before correction
    localparam int ESTY_W = $clog2(2 * H_MAX);

    // reciprocals floor(2^29 / size), one per segment count
    localparam int RCPX_W = $clog2((2 ** RCP_SHIFT) / SEGMENT_CELLS_WIDE + 1);
    localparam int RCPY_W = $clog2((2 ** RCP_SHIFT) / SEGMENT_CELLS_HIGH + 1);
    localparam int PWX_W  = CX_W + RCPX_W;
    localparam int PWY_W  = CX_W + RCPY_W;

    localparam logic [RCPX_W-1:0] RCPX_LUT [SEG_COUNT] = '{
        RCPX_W'((2 ** RCP_SHIFT) / (1 * SEGMENT_CELLS_WIDE)),
        RCPX_W'((2 ** RCP_SHIFT) / (2 * SEGMENT_CELLS_WIDE)),
        RCPX_W'((2 ** RCP_SHIFT) / (3 * SEGMENT_CELLS_WIDE)),
        RCPX_W'((2 ** RCP_SHIFT) / (4 * SEGMENT_CELLS_WIDE))
    };
    localparam logic [RCPY_W-1:0] RCPY_LUT [SEG_COUNT] = '{
        RCPY_W'((2 ** RCP_SHIFT) / (1 * SEGMENT_CELLS_HIGH)),
        RCPY_W'((2 ** RCP_SHIFT) / (2 * SEGMENT_CELLS_HIGH)),
        RCPY_W'((2 ** RCP_SHIFT) / (3 * SEGMENT_CELLS_HIGH)),
        RCPY_W'((2 ** RCP_SHIFT) / (4 * SEGMENT_CELLS_HIGH))
    };

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]        r_map_mode;
    logic signed [ORG_W-1:0]  r_origin_x;
    logic signed [MPAR_W-1:0] r_parallax;
    logic signed [ORG_W-1:0]  r_origin_y;
    logic [SEG_W-1:0]         r_wseg;
    logic [SEG_W-1:0]         r_hseg;
    logic                     r_ovf_en;
    logic [CELL_W-1:0]        r_ovf_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode <= '0;
            r_origin_x <= '0;
            r_parallax <= '0;
            r_origin_y <= '0;
            r_wseg     <= '0;
            r_hseg     <= '0;
            r_ovf_en   <= 1'b0;
            r_ovf_cell <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAP_MODE:      r_map_mode <= i_cfg_data[MODE_W-1:0];
                CFG_ORIGIN_X:      r_origin_x <= i_cfg_data[ORG_W-1:0];
                CFG_PARALLAX:      r_parallax <= i_cfg_data[MPAR_W-1:0];
                CFG_ORIGIN_Y:      r_origin_y <= i_cfg_data[ORG_W-1:0];
                CFG_WIDTH_SEGS:    r_wseg     <= i_cfg_data[SEG_W-1:0];
                CFG_HEIGHT_SEGS:   r_hseg     <= i_cfg_data[SEG_W-1:0];
                CFG_OVERFLOW_EN:   r_ovf_en   <= i_cfg_data[0];
                CFG_OVERFLOW_CELL: r_ovf_cell <= i_cfg_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // map size in cells and its reciprocal; user keeps them static while items are in flight, unchecked
    logic [WS_W-1:0]   ws;
    logic [HS_W-1:0]   hs;
    logic [RCPX_W-1:0] rcp_w;
    logic [RCPY_W-1:0] rcp_h;

    assign ws    = WS_W'((32'(r_wseg) + 32'd1) * 32'(SEGMENT_CELLS_WIDE));
    assign hs    = HS_W'((32'(r_hseg) + 32'd1) * 32'(SEGMENT_CELLS_HIGH));
    assign rcp_w = RCPX_LUT[r_wseg];
    assign rcp_h = RCPY_LUT[r_hseg];

    // ------------------------------------------------------------------
    // stage enable: every stage moves unless the output holds a result
    // that the sink has not taken yet
    // ------------------------------------------------------------------
    logic                  adv;
    logic [PIPE_DEPTH-1:0] r_vld;

    assign adv         = !r_vld[PIPE_DEPTH-1] || o_cell.ready;
    assign i_pix.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_pix.valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: normal / h-bias position, affine pixel distance
    // ------------------------------------------------------------------
    logic signed [NX_W-1:0]  n1_nx, n1_ny, n1_par, n1_bias;
    logic signed [B_W-1:0]   n1_b;
    logic                    n1_par_sel;

    logic                    r1_aff;
    logic signed [NX_W-1:0]  r1_nx, r1_ny;
    logic signed [B_W-1:0]   r1_b;
    logic signed [AFF_W-1:0] r1_mx, r1_my, r1_dx, r1_dy;

    always_comb begin
        // parallax subtracted for the left eye, added for the right
        n1_par  = i_pix.right_eye ? NX_W'(r_parallax) : -NX_W'(r_parallax);
        n1_bias = '0;
        if (r_map_mode == MODE_HBIAS) begin
            n1_bias = i_pix.right_eye ? NX_W'(i_pix.bias_right) : NX_W'(i_pix.bias_left);
        end
        n1_nx = NX_W'(r_origin_x) + n1_par + NX_W'(i_pix.window_x) + n1_bias;
        n1_ny = NX_W'(r_origin_y) + NX_W'(i_pix.window_y);

        // affine parallax goes to the eye its sign selects
        n1_par_sel = (!i_pix.affine_parallax[AFF_W-1]) == i_pix.right_eye;
        n1_b = B_W'(i_pix.window_x) + (n1_par_sel ? B_W'(i_pix.affine_parallax) : '0);
    end

    // ------------------------------------------------------------------
    // stage 2: step times distance
    // ------------------------------------------------------------------
    logic                    r2_aff;
    logic signed [NX_W-1:0]  r2_nx, r2_ny;
    logic signed [AFF_W-1:0] r2_mx, r2_my;
    logic signed [PROD_W-1:0] r2_px, r2_py;

    // ------------------------------------------------------------------
    // stage 3: start plus product, 1/512 pixel units
    // ------------------------------------------------------------------
    logic                    r3_aff;
    logic signed [NX_W-1:0]  r3_nx, r3_ny;
    logic signed [T_W-1:0]   r3_tx, r3_ty;

    // ------------------------------------------------------------------
    // stage 4: round half away from zero, pick the mode's position
    // negative t: -((-t + 256) >> 9) equals (t + 255) >>> 9
    // ------------------------------------------------------------------
    logic signed [T_W-1:0]   n4_rx, n4_ry;
    logic [POS_W-1:0]        n4_ux, n4_uy;
    logic [POS_W-1:0]        r4_ux, r4_uy;

    always_comb begin
        n4_rx = r3_tx + (r3_tx[T_W-1] ? T_W'(RND_HALF - 1) : T_W'(RND_HALF));
        n4_ry = r3_ty + (r3_ty[T_W-1] ? T_W'(RND_HALF - 1) : T_W'(RND_HALF));
        if (r3_aff) begin
            n4_ux = POS_W'(n4_rx >>> FRAC_SHIFT);
            n4_uy = POS_W'(n4_ry >>> FRAC_SHIFT);
        end else begin
            n4_ux = POS_W'(r3_nx);
            n4_uy = POS_W'(r3_ny);
        end
    end

    // ------------------------------------------------------------------
    // stage 5: cell coordinates, in-map test, reciprocal multiply
    // ------------------------------------------------------------------
    logic [CX_W-1:0]   n5_cx, n5_cy;
    logic [PWX_W-1:0]  r5_pw;
    logic [PWY_W-1:0]  r5_ph;
    logic [ESTX_W-1:0] r5_cxl;
    logic [ESTY_W-1:0] r5_cyl;
    logic              r5_inmap;
    logic [PIX_W-1:0]  r5_col, r5_row;

    assign n5_cx = r4_ux[POS_W-1:PIX_W];
    assign n5_cy = r4_uy[POS_W-1:PIX_W];

    // ------------------------------------------------------------------
    // stage 6: remainder = coordinate - quotient * size, one correction;
    // the estimate lies below twice the size so low bits suffice
    // ------------------------------------------------------------------
    logic [ESTX_W-1:0] n6_qx, n6_ex, n6_wse;
    logic [ESTY_W-1:0] n6_qy, n6_ey, n6_hse;
    logic [REMX_W-1:0] n6_rx;
    logic [REMY_W-1:0] n6_ry;
    logic [REMX_W-1:0] r6_rx;
    logic [REMY_W-1:0] r6_ry;
    logic              r6_inmap;
    logic [PIX_W-1:0]  r6_col, r6_row;

    always_comb begin
        n6_wse = ESTX_W'(ws);
        n6_hse = ESTY_W'(hs);
        n6_qx  = r5_pw[RCP_SHIFT +: ESTX_W];
        n6_qy  = r5_ph[RCP_SHIFT +: ESTY_W];
        n6_ex  = r5_cxl - n6_qx * n6_wse;
        n6_ey  = r5_cyl - n6_qy * n6_hse;
        n6_rx  = (n6_ex >= n6_wse) ? REMX_W'(n6_ex - n6_wse) : REMX_W'(n6_ex);
        n6_ry  = (n6_ey >= n6_hse) ? REMY_W'(n6_ey - n6_hse) : REMY_W'(n6_ey);
    end

    // ------------------------------------------------------------------
    // stage 7: row * width + column, or the overflow cell
    // inside the map the wrapped coordinates equal the plain ones
    // ------------------------------------------------------------------
    logic [CELL_W-1:0] n7_cell;
    logic [CELL_W-1:0] r7_cell;
    logic [PIX_W-1:0]  r7_col, r7_row;

    always_comb begin
        if (!r6_inmap && r_ovf_en) begin
            n7_cell = r_ovf_cell;
        end else begin
            n7_cell = CELL_W'(r6_ry) * CELL_W'(ws) + CELL_W'(r6_rx);
        end
    end

    // payload registers, all on the shared stage enable
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_aff   <= (r_map_mode == MODE_AFFINE);
            r1_nx    <= n1_nx;
            r1_ny    <= n1_ny;
            r1_b     <= n1_b;
            r1_mx    <= i_pix.affine_start_x;
            r1_my    <= i_pix.affine_start_y;
            r1_dx    <= i_pix.affine_step_x;
            r1_dy    <= i_pix.affine_step_y;

            r2_aff   <= r1_aff;
            r2_nx    <= r1_nx;
            r2_ny    <= r1_ny;
            r2_mx    <= r1_mx;
            r2_my    <= r1_my;
            r2_px    <= PROD_W'(r1_dx) * PROD_W'(r1_b);
            r2_py    <= PROD_W'(r1_dy) * PROD_W'(r1_b);

            r3_aff   <= r2_aff;
            r3_nx    <= r2_nx;
            r3_ny    <= r2_ny;
            r3_tx    <= (T_W'(r2_mx) <<< AFF_UP) + T_W'(r2_px);
            r3_ty    <= (T_W'(r2_my) <<< AFF_UP) + T_W'(r2_py);

            r4_ux    <= n4_ux;
            r4_uy    <= n4_uy;

            r5_pw    <= PWX_W'(n5_cx) * PWX_W'(rcp_w);
            r5_ph    <= PWY_W'(n5_cy) * PWY_W'(rcp_h);
            r5_cxl   <= n5_cx[ESTX_W-1:0];
            r5_cyl   <= n5_cy[ESTY_W-1:0];
            r5_inmap <= (n5_cx < CX_W'(ws)) && (n5_cy < CX_W'(hs));
            r5_col   <= r4_ux[PIX_W-1:0];
            r5_row   <= r4_uy[PIX_W-1:0];

            r6_rx    <= n6_rx;
            r6_ry    <= n6_ry;
            r6_inmap <= r5_inmap;
            r6_col   <= r5_col;
            r6_row   <= r5_row;

            r7_cell  <= n7_cell;
            r7_col   <= r6_col;
            r7_row   <= r6_row;
        end
    end

    // output register drives the result channel directly
    assign o_cell.valid      = r_vld[PIPE_DEPTH-1];
    assign o_cell.cell_index = r7_cell;
    assign o_cell.pixel_col  = r7_col;
    assign o_cell.pixel_row  = r7_row;

endmodule

`default_nettype wire

/* rtl/bgm_checker.sv */
// port-level checker for the cell address generator and its bind
`default_nettype none

`include "bgmap_cell_address_top_assert.svh"

module bgm_checker import bgm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire logic [CELL_W-1:0] i_cell_index,
    input  wire logic [PIX_W-1:0]  i_pixel_col,
    input  wire logic [PIX_W-1:0]  i_pixel_row
);

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

    // items taken in and not yet handed out
    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;

    assign n_inflight = r_inflight + CNT_W'(i_in_valid && i_in_ready)
                        - CNT_W'(i_out_valid && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    `BGM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_cell_index) && $stable(i_pixel_col) && $stable(i_pixel_row), "stalled result changed")
    `BGM_ASSERT_SAME(a_no_phantom, i_clk, i_rst_n, i_out_valid, r_inflight != '0, "result without a pending input")
    `BGM_ASSERT_SAME(a_depth, i_clk, i_rst_n, 1'b1, r_inflight <= CNT_W'(PIPE_DEPTH), "more items in flight than stages")
    `BGM_ASSERT_SAME(a_backpressure, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready, "input taken while output stalled")

endmodule

bind bgmap_cell_address_top bgm_checker u_bgm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_cell.valid),
    .i_out_ready  (o_cell.ready),
    .i_cell_index (o_cell.cell_index),
    .i_pixel_col  (o_cell.pixel_col),
    .i_pixel_row  (o_cell.pixel_row)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// self-checking testbench for the background map cell address generator
`timescale 1ns / 100ps

module testbench import bgm_pkg::*; ();

    // map geometry of the unit under test
    localparam int SEG_CELLS_WIDE = 64;
    localparam int SEG_CELLS_HIGH = 64;

    // mode codes the package leaves unnamed
    localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

    // run shape
    localparam int RANDOM_PHASES    = 10;
    localparam int PIXELS_PER_PHASE = 105;
    localparam int CYCLE_LIMIT      = 500000;

    // one pixel request as driven on the input channel
    typedef struct packed {
        logic [WIN_W-1:0]  window_x;
        logic [WIN_W-1:0]  window_y;
        logic              right_eye;
        logic [BIAS_W-1:0] bias_left;
        logic [BIAS_W-1:0] bias_right;
        logic [AFF_W-1:0]  affine_start_x;
        logic [AFF_W-1:0]  affine_start_y;
        logic [AFF_W-1:0]  affine_step_x;
        logic [AFF_W-1:0]  affine_step_y;
        logic [AFF_W-1:0]  affine_parallax;
    } pix_item_t;

    // one cell address as expected on the output channel
    typedef struct packed {
        logic [CELL_W-1:0] cell_index;
        logic [PIX_W-1:0]  pixel_col;
        logic [PIX_W-1:0]  pixel_row;
    } cell_addr_t;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bgm_pix_if  pix_chan ();
    bgm_cell_if cell_chan ();

    bgmap_cell_address_top #(
        .SEGMENT_CELLS_WIDE (SEG_CELLS_WIDE),
        .SEGMENT_CELLS_HIGH (SEG_CELLS_HIGH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (pix_chan),
        .o_cell      (cell_chan)
    );

    // copy of the configuration registers, kept in step with every write
    logic [MODE_W-1:0]  map_mode_reg;
    logic [ORG_W-1:0]   origin_x_reg;
    logic [MPAR_W-1:0]  parallax_reg;
    logic [ORG_W-1:0]   origin_y_reg;
    logic [SEG_W-1:0]   width_segs_reg;
    logic [SEG_W-1:0]   height_segs_reg;
    logic               overflow_en_reg;
    logic [CELL_W-1:0]  overflow_cell_reg;

    pix_item_t   pending_pixels [$];
    cell_addr_t  expected_cells [$];
    pix_item_t   driven_pixel;

    // idle percentages per side, changed from phase to phase
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned send_gap;
    int unsigned sink_stall;

    int unsigned sent_count;
    int unsigned result_count;
    int unsigned fail_count;
    int unsigned setting_count;
    int unsigned cycle_count;

    // clock, 12 ns period
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // t / 512 rounded half away from zero
    function automatic longint round_half_away(input longint t);
        if (t < 0) begin
            return -((-t + RND_HALF) >>> FRAC_SHIFT);
        end
        return (t + RND_HALF) >>> FRAC_SHIFT;
    endfunction

    // cell address of one pixel under the current register copy
    function automatic cell_addr_t cell_of_pixel(input pix_item_t p);
        longint src_x, src_y, distance, apar, org_x, par;
        int unsigned ux, uy, cx, cy, w, h, cell_idx;
        cell_addr_t r;
        if (map_mode_reg == MODE_AFFINE) begin
            // affine ignores window_y; parallax joins the distance when its sign fits the eye
            apar = longint'($signed(p.affine_parallax));
            distance = longint'(p.window_x);
            if ((apar >= 0) == p.right_eye) begin
                distance += apar;
            end
            src_x = round_half_away((longint'($signed(p.affine_start_x)) <<< AFF_UP)
                                    + longint'($signed(p.affine_step_x)) * distance);
            src_y = round_half_away((longint'($signed(p.affine_start_y)) <<< AFF_UP)
                                    + longint'($signed(p.affine_step_y)) * distance);
        end else begin
            // normal, h-bias and the spare mode code
            org_x = longint'($signed(origin_x_reg));
            par   = longint'($signed(parallax_reg));
            src_x = p.right_eye ? org_x + par + longint'(p.window_x)
                                : org_x - par + longint'(p.window_x);
            src_y = longint'($signed(origin_y_reg)) + longint'(p.window_y);
            if (map_mode_reg == MODE_HBIAS) begin
                src_x += p.right_eye ? longint'($signed(p.bias_right))
                                     : longint'($signed(p.bias_left));
            end
        end
        ux = src_x[31:0];
        uy = src_y[31:0];
        w  = (int'(width_segs_reg) + 1) * SEG_CELLS_WIDE;
        h  = (int'(height_segs_reg) + 1) * SEG_CELLS_HIGH;
        cx = ux >> PIX_W;
        cy = uy >> PIX_W;
        if (cx < w && cy < h) begin
            cell_idx = cy * w + cx;
        end else if (overflow_en_reg) begin
            cell_idx = 32'(overflow_cell_reg);
        end else begin
            cell_idx = (cy % h) * w + (cx % w);
        end
        r.cell_index = cell_idx[CELL_W-1:0];
        r.pixel_col  = ux[PIX_W-1:0];
        r.pixel_row  = uy[PIX_W-1:0];
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap(input int unsigned pct);
        if ($urandom_range(99) >= pct) begin
            return 0;
        end
        if ($urandom_range(9) == 0) begin
            return $urandom_range(40, 12);
        end
        return $urandom_range(3, 1);
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        unique case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return WIN_W'($urandom);
        endcase
    endfunction

    // signed register value, biased toward its extremes
    function automatic logic [CFG_DATA_W-1:0] pick_signed_reg(input int w);
        unique case ($urandom_range(3))
            0:       return CFG_DATA_W'(1) << (w - 1);
            1:       return (CFG_DATA_W'(1) << (w - 1)) - CFG_DATA_W'(1);
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic pix_item_t random_pixel();
        pix_item_t p;
        p.window_x   = pick_window();
        p.window_y   = pick_window();
        p.right_eye  = 1'($urandom_range(1));
        p.bias_left  = BIAS_W'($urandom);
        p.bias_right = BIAS_W'($urandom);
        if ($urandom_range(1) != 0) begin
            // sources near the map so that in-map cells show up often
            p.affine_start_x  = AFF_W'($urandom_range(16383));
            p.affine_start_y  = AFF_W'($urandom_range(16383));
            p.affine_step_x   = AFF_W'($urandom_range(1024) - 512);
            p.affine_step_y   = AFF_W'($urandom_range(1024) - 512);
            p.affine_parallax = AFF_W'($urandom_range(64) - 32);
        end else begin
            p.affine_start_x  = AFF_W'($urandom);
            p.affine_start_y  = AFF_W'($urandom);
            p.affine_step_x   = AFF_W'($urandom);
            p.affine_step_y   = AFF_W'($urandom);
            p.affine_parallax = AFF_W'($urandom);
        end
        return p;
    endfunction

    function automatic pix_item_t base_pixel(input logic [WIN_W-1:0] wx,
                                             input logic [WIN_W-1:0] wy,
                                             input logic eye);
        pix_item_t p;
        p = random_pixel();
        p.window_x  = wx;
        p.window_y  = wy;
        p.right_eye = eye;
        return p;
    endfunction

    function automatic pix_item_t affine_pixel(input logic [WIN_W-1:0] wx, input logic eye,
                                               input logic [AFF_W-1:0] sx,
                                               input logic [AFF_W-1:0] sy,
                                               input logic [AFF_W-1:0] dx,
                                               input logic [AFF_W-1:0] dy,
                                               input logic [AFF_W-1:0] par);
        pix_item_t p;
        p = base_pixel(wx, WIN_W'($urandom), eye);
        p.affine_start_x  = sx;
        p.affine_start_y  = sy;
        p.affine_step_x   = dx;
        p.affine_step_y   = dy;
        p.affine_parallax = par;
        return p;
    endfunction

    // one register write, the copy follows the masking of the hardware
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        unique case (idx)
            CFG_MAP_MODE:      map_mode_reg      = value[MODE_W-1:0];
            CFG_ORIGIN_X:      origin_x_reg      = value[ORG_W-1:0];
            CFG_PARALLAX:      parallax_reg      = value[MPAR_W-1:0];
            CFG_ORIGIN_Y:      origin_y_reg      = value[ORG_W-1:0];
            CFG_WIDTH_SEGS:    width_segs_reg    = value[SEG_W-1:0];
            CFG_HEIGHT_SEGS:   height_segs_reg   = value[SEG_W-1:0];
            CFG_OVERFLOW_EN:   overflow_en_reg   = value[0];
            CFG_OVERFLOW_CELL: overflow_cell_reg = value[CELL_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // all eight registers, only ever called with the pipe empty
    task automatic apply_setting(input logic [MODE_W-1:0] mode,
                                 input logic [CFG_DATA_W-1:0] ox, par, oy, ws, hs, ovf_en,
                                 input logic [CFG_DATA_W-1:0] ovf_cell);
        write_reg(CFG_MAP_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_PARALLAX, par);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_WIDTH_SEGS, ws);
        write_reg(CFG_HEIGHT_SEGS, hs);
        write_reg(CFG_OVERFLOW_EN, ovf_en);
        write_reg(CFG_OVERFLOW_CELL, ovf_cell);
        setting_count++;
    endtask

    // sampled on the falling edge, away from the driving edge
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_pixels.size() != 0 || pix_chan.valid || expected_cells.size() != 0);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    // input driver: every accepted transfer is predicted at its edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_chan.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (pix_chan.valid && pix_chan.ready) begin
                expected_cells.push_back(cell_of_pixel(driven_pixel));
                sent_count++;
            end
            // load the next pixel only when the current one has gone
            if (!pix_chan.valid || pix_chan.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    pix_chan.valid <= 1'b0;
                end else if (pending_pixels.size() > 0) begin
                    driven_pixel = pending_pixels.pop_front();
                    pix_chan.valid           <= 1'b1;
                    pix_chan.window_x        <= driven_pixel.window_x;
                    pix_chan.window_y        <= driven_pixel.window_y;
                    pix_chan.right_eye       <= driven_pixel.right_eye;
                    pix_chan.bias_left       <= driven_pixel.bias_left;
                    pix_chan.bias_right      <= driven_pixel.bias_right;
                    pix_chan.affine_start_x  <= driven_pixel.affine_start_x;
                    pix_chan.affine_start_y  <= driven_pixel.affine_start_y;
                    pix_chan.affine_step_x   <= driven_pixel.affine_step_x;
                    pix_chan.affine_step_y   <= driven_pixel.affine_step_y;
                    pix_chan.affine_parallax <= driven_pixel.affine_parallax;
                    send_gap = pick_gap(src_idle_pct);
                end else begin
                    pix_chan.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor: checks each transfer against the oldest prediction, stalls at random
    always @(posedge i_clk) begin
        cell_addr_t want;
        if (!i_rst_n) begin
            cell_chan.ready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (cell_chan.valid && cell_chan.ready) begin
                result_count++;
                if (expected_cells.size() == 0) begin
                    $display("%0t: unexpected cell transfer, cell %0d col %0d row %0d",
                             $time, cell_chan.cell_index, cell_chan.pixel_col,
                             cell_chan.pixel_row);
                    fail_count++;
                end else begin
                    want = expected_cells.pop_front();
                    if (cell_chan.cell_index !== want.cell_index)
                        report_mismatch("cell_index", 32'(want.cell_index),
                                        32'(cell_chan.cell_index));
                    if (cell_chan.pixel_col !== want.pixel_col)
                        report_mismatch("pixel_col", 32'(want.pixel_col),
                                        32'(cell_chan.pixel_col));
                    if (cell_chan.pixel_row !== want.pixel_row)
                        report_mismatch("pixel_row", 32'(want.pixel_row),
                                        32'(cell_chan.pixel_row));
                end
            end
            if (sink_stall > 0) begin
                sink_stall--;
                cell_chan.ready <= 1'b0;
            end else begin
                cell_chan.ready <= 1'b1;
                sink_stall = pick_gap(snk_idle_pct);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d predictions still open", $time, expected_cells.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        pix_item_t p;
        logic [MODE_W-1:0] mode;

        // every input known from time zero
        i_cfg_we                 = 1'b0;
        i_cfg_index              = '0;
        i_cfg_data               = '0;
        pix_chan.valid           = 1'b0;
        pix_chan.window_x        = '0;
        pix_chan.window_y        = '0;
        pix_chan.right_eye       = 1'b0;
        pix_chan.bias_left       = '0;
        pix_chan.bias_right      = '0;
        pix_chan.affine_start_x  = '0;
        pix_chan.affine_start_y  = '0;
        pix_chan.affine_step_x   = '0;
        pix_chan.affine_step_y   = '0;
        pix_chan.affine_parallax = '0;
        cell_chan.ready          = 1'b0;

        // registers come out of reset at zero
        map_mode_reg      = MODE_NORMAL;
        origin_x_reg      = '0;
        parallax_reg      = '0;
        origin_y_reg      = '0;
        width_segs_reg    = '0;
        height_segs_reg   = '0;
        overflow_en_reg   = 1'b0;
        overflow_cell_reg = '0;
        src_idle_pct      = 30;
        snk_idle_pct      = 30;
        sent_count        = 0;
        result_count      = 0;
        fail_count        = 0;
        setting_count     = 0;
        cycle_count       = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: window corners, the far corner wraps on a 64x64 map
        pending_pixels.push_back(base_pixel('0, '0, 1'b0));
        pending_pixels.push_back(base_pixel('1, '1, 1'b1));
        pending_pixels.push_back(base_pixel(10'd511, '1, 1'b0));
        wait_drained();

        // most negative origins, widest map: negative positions land on the overflow cell
        apply_setting(MODE_NORMAL, 16'h1000, 16'h01FF, 16'h1000, 16'd3, 16'd3, 16'd1,
                      16'hFFFF);
        pending_pixels.push_back(base_pixel('0, '0, 1'b0));
        pending_pixels.push_back(base_pixel('1, '1, 1'b1));
        pending_pixels.push_back(base_pixel('1, '0, 1'b1));
        wait_drained();

        // h-bias at the register and bias extremes on the smallest map, wrapping
        apply_setting(MODE_HBIAS, 16'h0FFF, 16'h0200, 16'h0FFF, 16'd0, 16'd0, 16'd0, 16'd0);
        p = base_pixel('0, '0, 1'b0);
        p.bias_left = 13'h1000;
        pending_pixels.push_back(p);
        p = base_pixel('1, '1, 1'b1);
        p.bias_right = 13'h0FFF;
        pending_pixels.push_back(p);
        p = base_pixel(10'd5, 10'd9, 1'b1);
        p.bias_right = 13'h1000;
        pending_pixels.push_back(p);
        p = base_pixel('1, '0, 1'b0);
        p.bias_left = 13'h0FFF;
        pending_pixels.push_back(p);
        wait_drained();

        // affine: exact halves round away from zero, field extremes, parallax eye select
        apply_setting(MODE_AFFINE, 16'd0, 16'd0, 16'd0, 16'd3, 16'd3, 16'd0, 16'd0);
        pending_pixels.push_back(affine_pixel(10'd1, 1'b1, '0, '0, 16'd256, 16'hFF00, '0));
        pending_pixels.push_back(affine_pixel(10'd1, 1'b1, '0, '0, 16'd255, 16'hFF01, '0));
        pending_pixels.push_back(affine_pixel('1, 1'b1, 16'h8000, 16'h8000, 16'h8000,
                                              16'h8000, 16'h7FFF));
        pending_pixels.push_back(affine_pixel('1, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                              16'h7FFF, 16'h8000));
        pending_pixels.push_back(affine_pixel(10'd7, 1'b1, 16'd64, 16'd64, 16'd512,
                                              16'd512, 16'hFFF0));
        pending_pixels.push_back(affine_pixel('0, 1'b0, 16'd40, 16'd40, 16'd512,
                                              16'd512, '0));
        wait_drained();

        // spare mode code acts as normal, with a fixed overflow cell
        apply_setting(MODE_SPARE, CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                      CFG_DATA_W'($urandom), 16'd1, 16'd2, 16'd1, CFG_DATA_W'($urandom));
        repeat (3) pending_pixels.push_back(random_pixel());
        wait_drained();

        // random settings; the pipe drains between them so no setting changes while a result is pending
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            unique case (phase % 4)
                0:       mode = MODE_AFFINE;
                1:       mode = MODE_HBIAS;
                2:       mode = MODE_NORMAL;
                default: mode = (phase == 3) ? MODE_SPARE : MODE_AFFINE;
            endcase
            // the source, the sink or both idle, so in some phases one side runs back to back
            src_idle_pct = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 20 : 50);
            snk_idle_pct = ((phase + 1) % 3 == 0) ? 0 : (((phase + 1) % 3 == 1) ? 20 : 50);
            apply_setting(mode, pick_signed_reg(ORG_W), pick_signed_reg(MPAR_W),
                          pick_signed_reg(ORG_W), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom));
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                pending_pixels.push_back(random_pixel());
                // hold the sender once mid-phase until the pipe is empty
                if (phase == 5 && n == PIXELS_PER_PHASE / 2)
                    wait_drained();
            end
            wait_drained();
        end

        // let any stray result surface
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        $display("run covered %0d pixel transfers over %0d map settings", sent_count,
                 setting_count);
        $display("all four mode codes, overflow cell and wraparound, %0d results checked",
                 result_count);
        if (fail_count == 0 && expected_cells.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
